@@ rtl/jsu_pkg.sv @@
// Shared types, codes and helper functions for the JSON string unescaper.
// No dependencies; every other file in rtl imports this package.
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX1,
        MODE_WAIT_BS,
        MODE_WAIT_U,
        MODE_HEX2
    } mode_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_DONE       = 3'd1;
    localparam logic [2:0] ST_MISS_QUOTE = 3'd2;
    localparam logic [2:0] ST_BAD_HEX    = 3'd3;
    localparam logic [2:0] ST_BAD_SURR   = 3'd4;
    localparam logic [2:0] ST_BAD_ESC    = 3'd5;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Decoder state carried from one request to the next.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex_value;
        logic [1:0]  digit_count;
        logic [9:0]  high_half;
        logic [15:0] dec_len;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        mode:        MODE_PLAIN,
        hex_value:   16'h0000,
        digit_count: 2'd0,
        high_half:   10'd0,
        dec_len:     16'h0000
    };

    // A group of results caused by one input byte: up to four data bytes,
    // or a single end-of-string result when is_end is set.
    typedef struct packed {
        logic            is_end;
        logic [2:0]      status;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
        logic [15:0]     len_base;
    } grp_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } enc_t;

    function automatic hex_t hex_digit(input logic [7:0] ch);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = ch[3:0];
        end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
            h.ok  = 1'b1;
            h.val = 4'(ch[3:0] + 4'd9);
        end
        return h;
    endfunction

    // UTF-8 encoding of a code point up to 21 bits.
    function automatic enc_t utf8_encode(input logic [20:0] u);
        enc_t e;
        e.bytes = '0;
        if (u <= 21'h7F) begin
            e.last_idx = 2'd0;
            e.bytes[0] = u[7:0];
        end else if (u <= 21'h7FF) begin
            e.last_idx = 2'd1;
            e.bytes[0] = 8'hC0 | {3'b000, u[10:6]};
            e.bytes[1] = 8'h80 | {2'b00, u[5:0]};
        end else if (u <= 21'hFFFF) begin
            e.last_idx = 2'd2;
            e.bytes[0] = 8'hE0 | {4'b0000, u[15:12]};
            e.bytes[1] = 8'h80 | {2'b00, u[11:6]};
            e.bytes[2] = 8'h80 | {2'b00, u[5:0]};
        end else begin
            e.last_idx = 2'd3;
            e.bytes[0] = 8'hF0 | {5'b00000, u[20:18]};
            e.bytes[1] = 8'h80 | {2'b00, u[17:12]};
            e.bytes[2] = 8'h80 | {2'b00, u[11:6]};
            e.bytes[3] = 8'h80 | {2'b00, u[5:0]};
        end
        return e;
    endfunction

endpackage

@@ rtl/json_string_unescape_utf8.sv @@
// JSON string unescaper with UTF-8 output. The first result of a byte is registered
// and appears in the cycle after the request is accepted. One input byte per cycle
// is taken while each byte yields at most one result and m_ready is high; a byte
// yielding more holds the input while the single port drains the result register.
// Reset (aresetn, synchronous, active low) returns the decoder to plain mode with
// zero length and empties the result register.
module json_string_unescape_utf8 #(
    parameter int unsigned MAX_LEN = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic [2:0]  m_status,
    output logic        m_last,
    output logic [15:0] m_length
);
    import jsu_pkg::*;

    localparam logic [15:0] LEN_CAP = (MAX_LEN > 65535) ? 16'hFFFF : 16'(MAX_LEN);

    dec_state_t st_reg;
    dec_state_t st_next;
    logic       emit;
    grp_t       grp;
    logic       grp_free;
    logic       accept;

    assign s_ready = grp_free;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= STATE_RESET;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    jsu_decode #(
        .LEN_CAP (LEN_CAP)
    ) u_decode (
        .st      (st_reg),
        .in_byte (s_in_byte),
        .st_next (st_next),
        .emit    (emit),
        .grp     (grp)
    );

    jsu_drain #(
        .LEN_CAP (LEN_CAP)
    ) u_drain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept && emit),
        .grp_in       (grp),
        .grp_free     (grp_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_status     (m_status),
        .m_last       (m_last),
        .m_length     (m_length)
    );

endmodule

@@ rtl/jsu_decode.sv @@
// Combinational byte decoder: next decoder state and the result group for one byte.
// Depends on jsu_pkg.
module jsu_decode #(
    parameter logic [15:0] LEN_CAP = 16'hFFFF
) (
    input  jsu_pkg::dec_state_t st,
    input  logic [7:0]          in_byte,
    output jsu_pkg::dec_state_t st_next,
    output logic                emit,
    output jsu_pkg::grp_t       grp
);
    import jsu_pkg::*;

    hex_t        hd;
    logic [15:0] hex_new;
    logic [20:0] pair_cp;
    enc_t        enc;
    logic [16:0] len_sum;

    assign hd      = hex_digit(in_byte);
    assign hex_new = {st.hex_value[11:0], hd.val};
    // Surrogate pair: the high half supplies bits 19:10, offset by 0x10000.
    assign pair_cp = {1'b0, st.high_half, hex_new[9:0]} + 21'h10000;
    assign enc     = utf8_encode((st.mode == MODE_HEX2) ? pair_cp : {5'b00000, hex_new});

    always_comb begin
        st_next      = st;
        emit         = 1'b0;
        grp.is_end   = 1'b0;
        grp.status   = ST_OK;
        grp.last_idx = 2'd0;
        grp.bytes    = '0;
        grp.len_base = st.dec_len;
        len_sum      = 17'd0;

        case (st.mode)
            MODE_PLAIN: begin
                if (in_byte == CH_QUOTE) begin
                    emit       = 1'b1;
                    grp.is_end = 1'b1;
                    grp.status = ST_DONE;
                end else if (in_byte == 8'h00) begin
                    emit       = 1'b1;
                    grp.is_end = 1'b1;
                    grp.status = ST_MISS_QUOTE;
                end else if (in_byte == CH_BSL) begin
                    st_next.mode = MODE_ESC;
                end else if (in_byte < CH_SPACE) begin
                    emit       = 1'b1;
                    grp.is_end = 1'b1;
                    grp.status = ST_BAD_CHAR;
                end else begin
                    emit         = 1'b1;
                    grp.bytes[0] = in_byte;
                end
            end
            MODE_ESC: begin
                emit         = 1'b1;
                st_next.mode = MODE_PLAIN;
                case (in_byte)
                    CH_QUOTE: grp.bytes[0] = CH_QUOTE;
                    CH_BSL:   grp.bytes[0] = CH_BSL;
                    CH_SLASH: grp.bytes[0] = CH_SLASH;
                    CH_LC_B:  grp.bytes[0] = 8'h08;
                    CH_LC_F:  grp.bytes[0] = 8'h0C;
                    CH_LC_N:  grp.bytes[0] = 8'h0A;
                    CH_LC_R:  grp.bytes[0] = 8'h0D;
                    CH_LC_T:  grp.bytes[0] = 8'h09;
                    CH_LC_U: begin
                        emit                = 1'b0;
                        st_next.mode        = MODE_HEX1;
                        st_next.hex_value   = 16'h0000;
                        st_next.digit_count = 2'd0;
                    end
                    default: begin
                        grp.is_end = 1'b1;
                        grp.status = ST_BAD_ESC;
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2: begin
                if (!hd.ok) begin
                    emit       = 1'b1;
                    grp.is_end = 1'b1;
                    grp.status = ST_BAD_HEX;
                end else begin
                    st_next.hex_value = hex_new;
                    if (st.digit_count != 2'd3) begin
                        st_next.digit_count = st.digit_count + 2'd1;
                    end else begin
                        st_next.digit_count = 2'd0;
                        if (st.mode == MODE_HEX1 && hex_new[15:10] == 6'b110110) begin
                            st_next.high_half = hex_new[9:0];
                            st_next.mode      = MODE_WAIT_BS;
                        end else if (st.mode == MODE_HEX2 && hex_new[15:10] != 6'b110111) begin
                            emit       = 1'b1;
                            grp.is_end = 1'b1;
                            grp.status = ST_BAD_SURR;
                        end else begin
                            emit         = 1'b1;
                            grp.last_idx = enc.last_idx;
                            grp.bytes    = enc.bytes;
                            st_next.mode = MODE_PLAIN;
                        end
                    end
                end
            end
            MODE_WAIT_BS: begin
                if (in_byte != CH_BSL) begin
                    emit       = 1'b1;
                    grp.is_end = 1'b1;
                    grp.status = ST_BAD_SURR;
                end else begin
                    st_next.mode = MODE_WAIT_U;
                end
            end
            MODE_WAIT_U: begin
                if (in_byte != CH_LC_U) begin
                    emit       = 1'b1;
                    grp.is_end = 1'b1;
                    grp.status = ST_BAD_SURR;
                end else begin
                    st_next.mode        = MODE_HEX2;
                    st_next.hex_value   = 16'h0000;
                    st_next.digit_count = 2'd0;
                end
            end
            default: begin
                st_next = STATE_RESET;
            end
        endcase

        // Any end of string returns the decoder to its reset state.
        if (emit && grp.is_end) begin
            st_next = STATE_RESET;
        end else if (emit) begin
            len_sum = {1'b0, st.dec_len} + {15'd0, grp.last_idx} + 17'd1;
            st_next.dec_len = (len_sum > {1'b0, LEN_CAP}) ? LEN_CAP : len_sum[15:0];
        end
    end

endmodule

@@ rtl/jsu_drain.sv @@
// Result group register and the sequencer that hands out its results one per cycle while m_ready is high.
// Depends on jsu_pkg.
module jsu_drain #(
    parameter logic [15:0] LEN_CAP = 16'hFFFF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  jsu_pkg::grp_t grp_in,
    output logic          grp_free,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_byte_valid,
    output logic [2:0]    m_status,
    output logic          m_last,
    output logic [15:0]   m_length
);
    import jsu_pkg::*;

    grp_t        grp_reg;
    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        at_last;
    logic [16:0] len_sum;

    assign at_last  = grp_reg.is_end || (idx_reg == grp_reg.last_idx);
    assign grp_free = !valid_reg || (m_ready && at_last);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (valid_reg && m_ready) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp_in;
        end
    end

    // Each data byte reports the running count with itself included.
    assign len_sum = {1'b0, grp_reg.len_base} + {15'd0, idx_reg} + 17'd1;

    assign m_valid      = valid_reg;
    assign m_byte_valid = !grp_reg.is_end;
    assign m_out_byte   = grp_reg.is_end ? 8'h00 : grp_reg.bytes[idx_reg];
    assign m_status     = grp_reg.status;
    assign m_last       = at_last;
    assign m_length     = grp_reg.is_end ? grp_reg.len_base :
                          (len_sum > {1'b0, LEN_CAP}) ? LEN_CAP : len_sum[15:0];

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> grp_free)
        else $error("result group loaded while results still pending");

    a_group_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && (idx_reg == $past(idx_reg) + 2'd1))
        else $error("result group cut short");

    a_end_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_last && !m_byte_valid)
        else $error("end of string result is not a single final result");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !grp_reg.is_end |-> idx_reg <= grp_reg.last_idx)
        else $error("result index beyond group size");

endmodule
